// File: rtl/core/sust_pkg.sv
package sust_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 7;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

// File: rtl/core/sorted_unique_set_table.sv
// Sorted set of up to CAPACITY signed 32-bit identifiers, kept ascending without duplicates
// in a row of compare-and-shift cells. Each item (opcode 0 add, 1 remove, 2 or 3 query)
// gives one result item: whether the value was present before, whether an add was refused
// because the set is full, and the count after the item (low 7 bits). An item is accepted
// in the idle state; in the compare state every cell compares its entry with the value; in
// the apply state, which waits while a stalled result is still held, the cells shift by one
// slot toward or away from the insertion point and the result is loaded into the output register.
// A new item is accepted only once the block is back in idle, after the last item has applied.
module sorted_unique_set_table #(
  parameter int unsigned CAPACITY = sust_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sust_pkg::OPCODE_W-1:0]       in_opcode,
  input  sust_pkg::value_t                    in_member_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_was_present,
  output logic                                out_full_refused,
  output logic [sust_pkg::COUNT_OUT_W-1:0]    out_member_count
);
  import sust_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [OPCODE_W-1:0]    op_r;
  value_t                 value_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   out_present_r;
  logic                   out_refused_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  value_t                 entry_vec [CAPACITY];
  logic [CAPACITY-1:0]    lt_vec;
  logic [CAPACITY-1:0]    eq_vec;
  logic [CAPACITY-1:0]    occ_vec;

  cell_cmd_t              cmd;
  logic                   accept;
  logic                   go;
  logic                   present;
  logic                   full;
  logic                   do_ins;
  logic                   do_del;
  logic                   refused;

  assign accept  = in_valid && (state_r == ST_IDLE);
  assign go      = (state_r == ST_APPLY) && (!out_valid_r || !out_stall);
  assign present = |eq_vec;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign do_ins  = (op_r == OP_ADD) && !present && !full;
  assign do_del  = (op_r == OP_REMOVE) && present;
  assign refused = (op_r == OP_ADD) && !present && full;

  assign cmd.cmp_en = (state_r == ST_CMP);
  assign cmd.ins    = go && do_ins;
  assign cmd.del    = go && do_del;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: if (go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      value_r <= in_member_value;
    end
    if (go) begin
      out_present_r <= present;
      out_refused_r <= refused;
      out_count_r   <= COUNT_OUT_W'(count_nxt);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_entry;
    value_t right_entry;
    logic   left_lt;

    assign occ_vec[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_entry = entry_vec[i];
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_vec[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry_vec[i];
    end else begin : g_inner
      assign right_entry = entry_vec[i+1];
    end

    sust_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .value       (value_r),
      .occ         (occ_vec[i]),
      .left_entry  (left_entry),
      .left_lt     (left_lt),
      .right_entry (right_entry),
      .entry       (entry_vec[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_was_present  = out_present_r;
  assign out_full_refused = out_refused_r;
  assign out_member_count = out_count_r;

endmodule

// File: rtl/core/sust_cell.sv
module sust_cell (
  input  logic               clk,
  input  sust_pkg::cell_cmd_t cmd,
  input  sust_pkg::value_t   value,
  input  logic               occ,
  input  sust_pkg::value_t   left_entry,
  input  logic               left_lt,
  input  sust_pkg::value_t   right_entry,
  output sust_pkg::value_t   entry,
  output logic               lt,
  output logic               eq
);
  import sust_pkg::*;

  value_t entry_r;
  value_t entry_nxt;
  logic   lt_r;
  logic   eq_r;

  // compare against the request, then open or close a slot at the boundary
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && !lt_r) begin
      entry_nxt = left_lt ? value : left_entry;
    end else if (cmd.del && !lt_r) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmd.cmp_en) begin
      lt_r <= occ && (entry_r < value);
      eq_r <= occ && (entry_r == value);
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// File: rtl/core/sust_checker.sv
module sust_checker #(
  parameter int unsigned CAPACITY = sust_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_was_present,
  input logic                             out_full_refused,
  input logic [sust_pkg::COUNT_OUT_W-1:0] out_member_count
);
  import sust_pkg::*;

  a_refused_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_refused |-> !out_was_present)
    else $error("refused add reports a present value");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_refused |-> out_member_count == COUNT_OUT_W'(CAPACITY))
    else $error("refused add with set not full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in progress");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_member_count))
    else $error("stalled result item changed");

endmodule

bind sorted_unique_set_table sust_checker #(.CAPACITY(CAPACITY)) u_sust_checker (.*);
